@@ rtl/dots_pkg.sv @@
// Shared types and constants for the deadline-ordered timer scheduler.
`timescale 1ns / 1ps
package dots_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_OUT       = 15;
    localparam int OP_W          = 2;
    localparam int PERIOD_W      = 24;
    localparam int ID_W          = 4;
    localparam int KIND_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_REGISTER = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_ACK      = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 2'd0,
        KIND_FULL       = 2'd1,
        KIND_FIRED      = 2'd2,
        KIND_DONE       = 2'd3
    } t_kind;

    // Classified command passed from the front end to the engine
    typedef struct packed {
        t_op                 op;
        logic [PERIOD_W-1:0] period;
        logic                periodic;
        logic [ID_W-1:0]     id;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_REG_WR,
        ST_SCAN,
        ST_DQ_RD,
        ST_DQ_RANK,
        ST_SWEEP,
        ST_FIRE,
        ST_TICK_END,
        ST_EMIT
    } t_bstate;

endpackage

@@ rtl/dots_if.sv @@
// Valid/ready channel interfaces for command input and result output.
`timescale 1ns / 1ps
interface dots_in_if;
    logic                          valid;
    logic                          ready;
    logic [dots_pkg::OP_W-1:0]     operation;
    logic [dots_pkg::PERIOD_W-1:0] period_ms;
    logic                          periodic;
    logic [dots_pkg::ID_W-1:0]     timer_id;

    modport source (output valid, operation, period_ms, periodic, timer_id, input ready);
    modport sink   (input valid, operation, period_ms, periodic, timer_id, output ready);
endinterface

interface dots_out_if;
    logic                        valid;
    logic                        ready;
    logic [dots_pkg::KIND_W-1:0] kind;
    logic [dots_pkg::ID_W-1:0]   fired_id;
    logic                        last;

    modport source (output valid, kind, fired_id, last, input ready);
    modport sink   (input valid, kind, fired_id, last, output ready);
endinterface

@@ rtl/dots_front.sv @@
// Front end: accepts commands, classifies them and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module dots_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dots_in_if.sink        i_in,
    output dots_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready
);

    dots_pkg::t_cmd r_fifo [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    dots_pkg::t_cmd n_cmd;
    logic           push;
    logic           pop;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_fifo[r_rp];

    // Classify: decode the operation, take a zero period as one
    always_comb begin
        n_cmd.op       = dots_pkg::t_op'(i_in.operation);
        n_cmd.period   = (i_in.period_ms == '0) ? dots_pkg::PERIOD_W'(1) : i_in.period_ms;
        n_cmd.periodic = i_in.periodic;
        n_cmd.id       = i_in.timer_id;
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= n_cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/dots_back.sv @@
// Engine: slot table, deadline scan, rank close-up sweep and result register.
`timescale 1ns / 1ps
module dots_back #(
    parameter int SLOTS     = dots_pkg::SLOTS_DEF,
    parameter int TIME_BITS = dots_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dots_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_valid,
    input  logic                          i_need_dq,
    output logic                          o_cmd_ready,
    dots_out_if.source                    o_out,
    output logic                          o_idle,
    output logic [SLOTS-1:0]              o_queued,
    output logic [$clog2(SLOTS+1)-1:0]    o_stamp_cnt
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Slot memories
    logic [TIME_BITS-1:0]          r_dl_mem    [SLOTS];
    logic [dots_pkg::PERIOD_W-1:0] r_per_mem   [SLOTS];
    logic                          r_rep_mem   [SLOTS];
    logic [CNT_W-1:0]              r_stamp_mem [SLOTS];

    logic [TIME_BITS-1:0]          r_rd_dl;
    logic [dots_pkg::PERIOD_W-1:0] r_rd_per;
    logic                          r_rd_rep;
    logic [CNT_W-1:0]              r_rd_stamp;

    // Slot flags
    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] r_queued;
    logic [SLOTS-1:0] r_pend;
    logic [SLOTS-1:0] r_done;

    dots_pkg::t_bstate r_state, n_state, r_ret;
    dots_pkg::t_cmd    r_cmd;
    logic [TIME_BITS-1:0] r_now;
    logic [CNT_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_steps;
    logic [CNT_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_tgt;
    logic [CNT_W-1:0]     r_rank;
    logic                 r_rep_s;
    logic [dots_pkg::PERIOD_W-1:0] r_per_s;
    logic [3:0]           r_n;

    // Scan pipeline
    logic                 r_p1_v;
    logic [IDX_W-1:0]     r_p1_idx;
    logic                 r_p2_v;
    logic [IDX_W-1:0]     r_p2_idx;
    logic [TIME_BITS-1:0] r_p2_late;
    logic [CNT_W-1:0]     r_p2_stamp;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best;
    logic [TIME_BITS-1:0] r_best_late;
    logic [CNT_W-1:0]     r_best_stamp;

    // Held fire result and emit payload
    logic                 r_hold_v;
    logic [IDX_W-1:0]     r_hold_id;
    dots_pkg::t_kind      r_ekind;
    logic [dots_pkg::ID_W-1:0] r_eid;

    // Output register
    logic                      r_ov;
    dots_pkg::t_kind           r_okind;
    logic [dots_pkg::ID_W-1:0] r_oid;
    logic                      r_olast;

    logic                 out_free;
    logic                 out_ld;
    dots_pkg::t_kind      out_kind;
    logic [dots_pkg::ID_W-1:0] out_id;
    logic                 out_last;
    logic [IDX_W-1:0]     cmd_idx;
    logic                 cmd_hit;
    logic [IDX_W-1:0]     nxt_ptr;
    logic                 alloc_hit;
    logic                 alloc_last;
    logic                 scan_end;
    logic                 sweep_end;
    logic                 fire;
    logic                 fire_stall;
    logic                 idx_run;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_BITS-1:0] p1_late;
    logic                 p1_ok;
    logic                 better;
    logic                 st_we;
    logic [IDX_W-1:0]     st_addr;
    logic [CNT_W-1:0]     st_data;
    logic                 dl_we;
    logic [TIME_BITS-1:0] dl_data;

    assign out_free   = !r_ov || o_out.ready;
    assign cmd_idx    = IDX_W'(r_cmd.id);
    assign cmd_hit    = (r_cmd.id != '0) && (int'(r_cmd.id) < SLOTS) && r_used[cmd_idx];
    assign nxt_ptr    = (r_ptr == IDX_W'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign alloc_hit  = (nxt_ptr != '0) && !r_used[nxt_ptr];
    assign alloc_last = (r_steps == CNT_W'(SLOTS - 1));
    assign idx_run    = (r_idx != CNT_W'(SLOTS));
    assign scan_end   = !idx_run && !r_p1_v && !r_p2_v;
    assign sweep_end  = !idx_run && !r_p1_v;
    assign fire       = !(r_rep_s && r_pend[r_tgt]);
    assign fire_stall = fire && r_hold_v && !out_free;

    assign o_cmd_ready  = (r_state == dots_pkg::ST_IDLE);
    assign o_idle       = (r_state == dots_pkg::ST_IDLE);
    assign o_queued     = r_queued;
    assign o_stamp_cnt  = r_cnt;
    assign o_out.valid    = r_ov;
    assign o_out.kind     = r_okind;
    assign o_out.fired_id = r_oid;
    assign o_out.last     = r_olast;

    // Lateness of the slot whose data just came back; due when the top bit is clear
    assign p1_late = r_now - r_rd_dl;
    assign p1_ok   = r_queued[r_p1_idx] && !r_done[r_p1_idx] && !p1_late[TIME_BITS-1];
    assign better  = !r_found || (r_p2_late > r_best_late) ||
                     ((r_p2_late == r_best_late) && (r_p2_stamp < r_best_stamp));

    // Memory read address
    always_comb begin
        case (r_state)
            dots_pkg::ST_DQ_RD: rd_addr = r_tgt;
            default:            rd_addr = r_idx[IDX_W-1:0];
        endcase
    end

    // Memory write selection
    always_comb begin
        st_we   = 1'b0;
        st_addr = r_tgt;
        st_data = r_cnt;
        dl_we   = 1'b0;
        dl_data = r_now + TIME_BITS'(r_cmd.period);
        case (r_state)
            dots_pkg::ST_REG_WR: begin
                st_we = 1'b1;
                dl_we = 1'b1;
            end
            dots_pkg::ST_FIRE: begin
                if (!fire_stall && r_rep_s) begin
                    st_we   = 1'b1;
                    dl_we   = 1'b1;
                    dl_data = r_now + TIME_BITS'(r_per_s);
                end
            end
            dots_pkg::ST_SWEEP: begin
                if (r_p1_v && r_queued[r_p1_idx] && (r_rd_stamp > r_rank)) begin
                    st_we   = 1'b1;
                    st_addr = r_p1_idx;
                    st_data = r_rd_stamp - 1'b1;
                end
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    // Slot memories
    always_ff @(posedge i_clk) begin
        if (st_we) r_stamp_mem[st_addr] <= st_data;
        if (dl_we) r_dl_mem[r_tgt] <= dl_data;
        if (r_state == dots_pkg::ST_REG_WR) begin
            r_per_mem[r_tgt] <= r_cmd.period;
            r_rep_mem[r_tgt] <= r_cmd.periodic;
        end
        r_rd_dl    <= r_dl_mem[rd_addr];
        r_rd_per   <= r_per_mem[rd_addr];
        r_rd_rep   <= r_rep_mem[rd_addr];
        r_rd_stamp <= r_stamp_mem[rd_addr];
    end

    // Output load selection
    always_comb begin
        out_ld   = 1'b0;
        out_kind = dots_pkg::KIND_FIRED;
        out_id   = dots_pkg::ID_W'(r_hold_id);
        out_last = 1'b0;
        case (r_state)
            dots_pkg::ST_EMIT: begin
                out_ld   = out_free;
                out_kind = r_ekind;
                out_id   = r_eid;
                out_last = 1'b1;
            end
            dots_pkg::ST_FIRE: begin
                out_ld = fire && r_hold_v && out_free;
            end
            dots_pkg::ST_TICK_END: begin
                out_ld   = r_hold_v && out_free;
                out_last = 1'b1;
            end
            default: begin
                out_ld = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dots_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        dots_pkg::OP_TICK:     n_state = dots_pkg::ST_SCAN;
                        dots_pkg::OP_REGISTER: n_state = dots_pkg::ST_ALLOC;
                        default: n_state = i_need_dq ? dots_pkg::ST_DQ_RD
                                                     : dots_pkg::ST_EMIT;
                    endcase
                end
            end
            dots_pkg::ST_ALLOC: begin
                if (alloc_hit)       n_state = dots_pkg::ST_REG_WR;
                else if (alloc_last) n_state = dots_pkg::ST_EMIT;
            end
            dots_pkg::ST_REG_WR: n_state = dots_pkg::ST_EMIT;
            dots_pkg::ST_SCAN: begin
                if (scan_end) n_state = r_found ? dots_pkg::ST_DQ_RD : dots_pkg::ST_TICK_END;
            end
            dots_pkg::ST_DQ_RD:   n_state = dots_pkg::ST_DQ_RANK;
            dots_pkg::ST_DQ_RANK: n_state = dots_pkg::ST_SWEEP;
            dots_pkg::ST_SWEEP: begin
                if (sweep_end) n_state = r_ret;
            end
            dots_pkg::ST_FIRE: begin
                if (!fire_stall) begin
                    n_state = (fire && (r_n == 4'(dots_pkg::MAX_OUT - 1)))
                            ? dots_pkg::ST_TICK_END : dots_pkg::ST_SCAN;
                end
            end
            dots_pkg::ST_TICK_END: begin
                if (!r_hold_v || out_free) n_state = dots_pkg::ST_IDLE;
            end
            dots_pkg::ST_EMIT: begin
                if (out_free) n_state = dots_pkg::ST_IDLE;
            end
            default: n_state = dots_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dots_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Scan pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_idx   <= r_idx[IDX_W-1:0];
        r_p2_idx   <= r_p1_idx;
        r_p2_late  <= p1_late;
        r_p2_stamp <= r_rd_stamp;
        r_per_s    <= (r_state == dots_pkg::ST_DQ_RANK) ? r_rd_per : r_per_s;
    end

    // Control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_queued <= '0;
            r_pend   <= '0;
            r_done   <= '0;
            r_now    <= '0;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_steps  <= '0;
            r_idx    <= '0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_found  <= 1'b0;
            r_hold_v <= 1'b0;
            r_n      <= '0;
            r_ov     <= 1'b0;
            r_ret    <= dots_pkg::ST_IDLE;
        end else begin
            // Advance the scan index and read pipeline
            r_p1_v <= ((r_state == dots_pkg::ST_SCAN) || (r_state == dots_pkg::ST_SWEEP))
                      && idx_run;
            r_p2_v <= r_p1_v && p1_ok && (r_state == dots_pkg::ST_SCAN);
            if (((r_state == dots_pkg::ST_SCAN) || (r_state == dots_pkg::ST_SWEEP)) && idx_run)
                r_idx <= r_idx + 1'b1;

            // Output register
            if (out_ld) begin
                r_ov    <= 1'b1;
                r_okind <= out_kind;
                r_oid   <= out_id;
                r_olast <= out_last;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                dots_pkg::ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.op == dots_pkg::OP_TICK) begin
                            r_now   <= r_now + 1'b1;
                            r_done  <= '0;
                            r_n     <= '0;
                            r_found <= 1'b0;
                            r_idx   <= '0;
                        end
                        if (i_need_dq) r_tgt <= IDX_W'(i_cmd.id);
                        r_steps <= '0;
                        r_ekind <= dots_pkg::KIND_DONE;
                        r_eid   <= i_cmd.id;
                    end
                end
                dots_pkg::ST_ALLOC: begin
                    r_ptr   <= nxt_ptr;
                    r_steps <= r_steps + 1'b1;
                    r_tgt   <= nxt_ptr;
                    if (!alloc_hit && alloc_last) begin
                        r_ekind <= dots_pkg::KIND_FULL;
                        r_eid   <= '0;
                    end
                end
                dots_pkg::ST_REG_WR: begin
                    r_used[r_tgt]   <= 1'b1;
                    r_pend[r_tgt]   <= 1'b0;
                    r_queued[r_tgt] <= 1'b1;
                    r_cnt           <= r_cnt + 1'b1;
                    r_ekind         <= dots_pkg::KIND_REGISTERED;
                    r_eid           <= dots_pkg::ID_W'(r_tgt);
                end
                dots_pkg::ST_SCAN: begin
                    if (r_p2_v && better) begin
                        r_found      <= 1'b1;
                        r_best       <= r_p2_idx;
                        r_best_late  <= r_p2_late;
                        r_best_stamp <= r_p2_stamp;
                    end
                    if (scan_end && r_found) begin
                        r_tgt <= r_best;
                        r_ret <= dots_pkg::ST_FIRE;
                    end
                end
                dots_pkg::ST_DQ_RANK: begin
                    r_rank          <= r_rd_stamp;
                    r_rep_s         <= r_rd_rep;
                    r_queued[r_tgt] <= 1'b0;
                    if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                    r_idx <= '0;
                end
                dots_pkg::ST_FIRE: begin
                    if (!fire_stall) begin
                        r_done[r_tgt] <= 1'b1;
                        if (fire) begin
                            r_pend[r_tgt] <= 1'b1;
                            r_hold_v      <= 1'b1;
                            r_hold_id     <= r_tgt;
                            r_n           <= r_n + 1'b1;
                        end
                        if (r_rep_s) begin
                            r_queued[r_tgt] <= 1'b1;
                            r_cnt           <= r_cnt + 1'b1;
                        end
                        r_found <= 1'b0;
                        r_idx   <= '0;
                    end
                end
                dots_pkg::ST_TICK_END: begin
                    if (out_free) r_hold_v <= 1'b0;
                end
                default: begin
                    r_hold_v <= r_hold_v;
                end
            endcase

            // Remove and acknowledge act on the table as their answer is loaded
            if ((r_state == dots_pkg::ST_EMIT) && (r_ekind == dots_pkg::KIND_DONE)
                && cmd_hit && out_free) begin
                r_pend[cmd_idx] <= 1'b0;
                if (r_cmd.op == dots_pkg::OP_REMOVE) r_used[cmd_idx] <= 1'b0;
            end
            if (r_state == dots_pkg::ST_IDLE) begin
                r_ret <= dots_pkg::ST_EMIT;
            end
        end
    end

endmodule

@@ rtl/dots_remove.sv @@
// Remove path: routes a remove of a queued slot through the rank close-up sweep.
`timescale 1ns / 1ps
module dots_remove #(
    parameter int SLOTS = dots_pkg::SLOTS_DEF
) (
    input  dots_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    input  logic [SLOTS-1:0] i_queued,
    output logic           o_need_dq
);

    localparam int IDX_W = $clog2(SLOTS);

    logic id_ok;

    // Flag a remove whose slot sits in the queue
    assign id_ok     = (i_cmd.id != '0) && (int'(i_cmd.id) < SLOTS);
    assign o_need_dq = i_cmd_valid && (i_cmd.op == dots_pkg::OP_REMOVE) && id_ok
                       && i_queued[IDX_W'(i_cmd.id)];

endmodule

@@ rtl/deadline_ordered_timer_scheduler_top.sv @@
// Top level of the deadline-ordered timer scheduler.
`timescale 1ns / 1ps
// Timer slot table with a millisecond time base. Commands (tick, register, remove,
// acknowledge) enter a two-entry queue and are carried out one at a time by the engine;
// every result passes through a one-deep output register, so the next command is taken
// while a result waits. Register probes one slot per cycle in the allocation search.
// Remove and acknowledge answer directly, or, when the removed timer is queued, after
// the sweep that closes up the insertion ranks. A tick runs the deadline scan, one slot
// read per cycle from the slot memory; each timer it handles adds the scan that picks it,
// the dequeue and rank sweep, and the fire step; at most 15 timers fire per tick. A full
// output register stalls these steps. No clearing pass is needed after reset.
module deadline_ordered_timer_scheduler_top #(
    parameter int SLOTS     = dots_pkg::SLOTS_DEF,
    parameter int TIME_BITS = dots_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dots_in_if.sink    i_in,
    dots_out_if.source o_out
);

    dots_pkg::t_cmd             cmd;
    logic                       cmd_valid;
    logic                       cmd_ready;
    logic                       eng_idle;
    logic [SLOTS-1:0]           queued;
    logic [$clog2(SLOTS+1)-1:0] stamp_cnt;
    logic                       need_dq;

    dots_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    dots_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .i_need_dq   (need_dq),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out),
        .o_idle      (eng_idle),
        .o_queued    (queued),
        .o_stamp_cnt (stamp_cnt)
    );

    dots_remove #(
        .SLOTS (SLOTS)
    ) u_remove (
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .i_queued    (queued),
        .o_need_dq   (need_dq)
    );

`ifndef SYNTH
    // Rank counter tracks the number of queued timers between commands
    a_rank_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_idle |-> (int'(stamp_cnt) == $countones(queued)))
        else $error("rank counter out of step with queued timers");

    // A failed register answers id zero and closes its command
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == dots_pkg::KIND_FULL)) |->
        ((o_out.fired_id == '0) && o_out.last))
        else $error("full result malformed");

    // Registered and done results are always the single result of their command
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && ((o_out.kind == dots_pkg::KIND_REGISTERED) ||
                         (o_out.kind == dots_pkg::KIND_DONE))) |-> o_out.last)
        else $error("command result not marked last");

    // A remove of a queued timer leaves it dequeued once taken by the engine
    a_remove_dq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (need_dq && cmd_ready) |-> ##3 !queued[$past(cmd.id, 3) % SLOTS])
        else $error("removed timer still queued");
`endif

endmodule
